>>> rtl/ctd_pkg.sv
// Shared types, constants and helpers of the class-limited task dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package ctd_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int RUN_W       = 8;
	localparam int CTR_W       = 32;
	localparam int LIMIT_W     = 8;
	localparam logic [RUN_W-1:0]   RUN_MAX       = '1;
	localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = LIMIT_W'(4);

	typedef enum logic [1:0] {
		MODE_SUBMIT = 2'd0,
		MODE_CLAIM  = 2'd1,
		MODE_FINISH = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CLS_UNBOUND = 2'd0,
		CLS_CPU     = 2'd1,
		CLS_IO      = 2'd2
	} cls_t;

	typedef enum logic [2:0] {
		ST_GRANTED      = 3'd0,
		ST_WAIT         = 3'd1,
		ST_ALL_DONE     = 3'd2,
		ST_ACCEPTED     = 3'd3,
		ST_FULL         = 3'd4,
		ST_FINISH_ERROR = 3'd5
	} status_t;

	typedef enum logic [0:0] {
		CFG_CPU_LIMIT = 1'b0,
		CFG_IO_LIMIT  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cls_t                cls;
		logic [ID_WIDTH-1:0] id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef logic [2:0][RUN_W-1:0] class_run_t;

	// Update request from the sequencer to the counter bank.
	typedef struct packed {
		logic submit;
		logic grant;
		cls_t grant_cls;
		logic finish;
		cls_t fin_cls;
		logic fin_failed;
	} stats_cmd_t;

	// Class three folds onto the unbound class.
	function automatic cls_t norm_class(input logic [1:0] raw);
		cls_t c;
		c = CLS_UNBOUND;
		if (raw == CLS_CPU)
			c = CLS_CPU;
		else if (raw == CLS_IO)
			c = CLS_IO;
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/class_limited_task_dispatcher_core.sv
// Top level of the class-limited task dispatcher: sequencer, queue memory, counters.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per beat: submit,
//   claim, finish or no-op. The block takes one beat, then raises in_stall until the
//   result has been moved into the output register.
//   Output channel (out_valid / out_stall) carries one result beat per input beat.
//   A result waiting under out_stall does not block the next input beat; the
//   sequencer only holds in its final state if a second result is ready before
//   the first one was taken.
//   Configuration channel (cfg_valid / cfg_ready) writes the class limits; it is
//   always ready and should be used only while the block is idle.
// Sequencing:
//   Submit, finish, no-op and a claim that needs no scan pass through the execute
//   and response states before out_valid rises; in_stall falls as the result is
//   loaded into the output register, and the next beat can then be taken.
//   A claim scans the queue oldest first through one eligibility compare, one
//   entry per cycle; on a grant it closes the gap from the hole one entry per
//   cycle through the queue RAM port, and then goes to the response state.
// Reset: queue empty, all counts zero, both limits 4, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module class_limited_task_dispatcher_core
	import ctd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// operation channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          mode,
	input  wire logic [15:0]         task_id,
	input  wire logic [1:0]          task_class,
	input  wire logic                task_failed,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [2:0]          status,
	output logic      [15:0]         grant_id,
	output logic      [1:0]          grant_class,
	output logic      [RUN_W-1:0]    running_total,
	output logic      [CTR_W-1:0]    submitted_total,
	output logic      [CTR_W-1:0]    done_total,
	output logic      [CTR_W-1:0]    failed_total,
	// configuration channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [LIMIT_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t              state_q;

	// latched operation
	mode_t               op_mode_q;
	logic [ID_WIDTH-1:0] op_id_q;
	cls_t                op_cls_q;
	logic                op_failed_q;

	// queue bookkeeping
	logic [CNT_W-1:0]    cnt_q;
	logic [PTR_W-1:0]    ptr_q;

	// limits
	logic [LIMIT_W-1:0]  cpu_limit_q;
	logic [LIMIT_W-1:0]  io_limit_q;

	// result under construction
	status_t             res_status_q;
	logic [ID_WIDTH-1:0] res_id_q;
	cls_t                res_cls_q;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [15:0]         out_id_q;
	cls_t                out_cls_q;
	logic [RUN_W-1:0]    out_run_q;
	logic [CTR_W-1:0]    out_sub_q;
	logic [CTR_W-1:0]    out_done_q;
	logic [CTR_W-1:0]    out_fail_q;

	// counter bank
	stats_cmd_t          cmd;
	logic [RUN_W-1:0]    running;
	class_run_t          class_run;
	logic [CTR_W-1:0]    submitted;
	logic [CTR_W-1:0]    done;
	logic [CTR_W-1:0]    failed;

	// queue memory
	logic                ram_we;
	logic [PTR_W-1:0]    ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [PTR_W-1:0]    ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;

	entry_t              rd_entry;
	logic                elig;
	logic                q_full;
	logic                fin_err;
	logic [CNT_W-1:0]    ptr_next;
	logic                ptr_last;
	logic                out_free;

	assign rd_entry = entry_t'(ram_rdata);
	assign q_full   = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign fin_err  = (class_run[op_cls_q] == '0) || (running == '0);
	assign ptr_next = CNT_W'(ptr_q) + CNT_W'(1);
	assign ptr_last = (ptr_next >= cnt_q);
	assign out_free = !out_valid_q || !out_stall;

	// Shared eligibility compare: the class of the entry on the read port
	// against its limit.
	always_comb begin
		unique case (rd_entry.cls)
			CLS_CPU: elig = (class_run[CLS_CPU] < cpu_limit_q);
			CLS_IO:  elig = (class_run[CLS_IO] < io_limit_q);
			default: elig = 1'b1;
		endcase
	end

	// The read port runs one address ahead of ptr_q while scanning, and two
	// ahead while compacting, so the entry behind the hole is always on rdata.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata;
		ram_raddr = '0;
		unique case (state_q)
			S_EXEC: begin
				ram_we    = (op_mode_q == MODE_SUBMIT) && !q_full;
				ram_waddr = PTR_W'(cnt_q);
				ram_wdata = {op_cls_q, op_id_q};
			end
			S_SCAN: begin
				ram_raddr = ptr_q + PTR_W'(1);
			end
			S_SHIFT: begin
				ram_we    = !ptr_last;
				ram_raddr = ptr_q + PTR_W'(2);
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.submit     = (state_q == S_EXEC) && (op_mode_q == MODE_SUBMIT) && !q_full;
		cmd.grant      = (state_q == S_SCAN) && elig;
		cmd.grant_cls  = rd_entry.cls;
		cmd.finish     = (state_q == S_EXEC) && (op_mode_q == MODE_FINISH) && !fin_err;
		cmd.fin_cls    = op_cls_q;
		cmd.fin_failed = op_failed_q;
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ptr_q        <= '0;
			op_mode_q    <= MODE_SUBMIT;
			op_id_q      <= '0;
			op_cls_q     <= CLS_UNBOUND;
			op_failed_q  <= 1'b0;
			res_status_q <= ST_ACCEPTED;
			res_id_q     <= '0;
			res_cls_q    <= CLS_UNBOUND;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_ACCEPTED;
			out_id_q     <= '0;
			out_cls_q    <= CLS_UNBOUND;
			out_run_q    <= '0;
			out_sub_q    <= '0;
			out_done_q   <= '0;
			out_fail_q   <= '0;
		end else begin
			// Load a new result beat, or drop the current one once taken.
			if (state_q == S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_mode_q   <= mode_t'(mode);
						op_id_q     <= ID_WIDTH'(task_id);
						op_cls_q    <= norm_class(task_class);
						op_failed_q <= task_failed;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_id_q  <= '0;
					res_cls_q <= CLS_UNBOUND;
					state_q   <= S_RESP;
					unique case (op_mode_q)
						MODE_SUBMIT: begin
							if (q_full) begin
								res_status_q <= ST_FULL;
							end else begin
								res_status_q <= ST_ACCEPTED;
								cnt_q        <= cnt_q + CNT_W'(1);
							end
						end
						MODE_CLAIM: begin
							if (cnt_q == '0) begin
								res_status_q <= (running == '0) ? ST_ALL_DONE : ST_WAIT;
							end else if (running == RUN_MAX) begin
								res_status_q <= ST_WAIT;
							end else begin
								ptr_q   <= '0;
								state_q <= S_SCAN;
							end
						end
						MODE_FINISH: begin
							res_status_q <= fin_err ? ST_FINISH_ERROR : ST_ACCEPTED;
						end
						default: begin
							res_status_q <= ST_ACCEPTED;
						end
					endcase
				end
				S_SCAN: begin
					if (elig) begin
						// grant: keep ptr_q on the hole and start compaction
						res_status_q <= ST_GRANTED;
						res_id_q     <= rd_entry.id;
						res_cls_q    <= rd_entry.cls;
						state_q      <= S_SHIFT;
					end else if (ptr_last) begin
						res_status_q <= ST_WAIT;
						state_q      <= S_RESP;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				S_SHIFT: begin
					if (ptr_last) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_id_q     <= 16'(res_id_q);
						out_cls_q    <= res_cls_q;
						out_run_q    <= running;
						out_sub_q    <= submitted;
						out_done_q   <= done;
						out_fail_q   <= failed;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Class limits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_limit_q <= LIMIT_DEFAULT;
			io_limit_q  <= LIMIT_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CPU_LIMIT: cpu_limit_q <= cfg_data;
				CFG_IO_LIMIT:  io_limit_q  <= cfg_data;
				default:       cpu_limit_q <= cpu_limit_q;
			endcase
		end
	end

	ctd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ctd_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.running  (running),
		.class_run(class_run),
		.submitted(submitted),
		.done     (done),
		.failed   (failed)
	);

	assign in_stall        = (state_q != S_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign grant_id        = out_id_q;
	assign grant_class     = out_cls_q;
	assign running_total   = out_run_q;
	assign submitted_total = out_sub_q;
	assign done_total      = out_done_q;
	assign failed_total    = out_fail_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("pending count beyond queue depth");

	a_resp_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result raised outside the response state");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SHIFT) |-> (CNT_W'(ptr_q) < cnt_q))
		else $error("scan pointer past the pending entries");

	a_grant_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_GRANTED) |-> (out_run_q != '0))
		else $error("grant reported with nothing running");
`endif

endmodule

`default_nettype wire

>>> rtl/ctd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ctd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/ctd_stats.sv
// Running counts per class and the saturating submit, done and failed counters.
`timescale 1ns / 1ps
`default_nettype none

module ctd_stats
	import ctd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire stats_cmd_t       cmd,
	output logic      [RUN_W-1:0] running,
	output class_run_t            class_run,
	output logic      [CTR_W-1:0] submitted,
	output logic      [CTR_W-1:0] done,
	output logic      [CTR_W-1:0] failed
);

	logic [RUN_W-1:0] running_q;
	class_run_t       class_run_q;
	logic [CTR_W-1:0] submitted_q;
	logic [CTR_W-1:0] done_q;
	logic [CTR_W-1:0] failed_q;

	function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
		return (v == '1) ? v : v + CTR_W'(1);
	endfunction

	// Grant and finish never come in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= '0;
			class_run_q <= '0;
			submitted_q <= '0;
			done_q      <= '0;
			failed_q    <= '0;
		end else begin
			if (cmd.submit)
				submitted_q <= sat_inc(submitted_q);
			if (cmd.grant) begin
				running_q                  <= running_q + RUN_W'(1);
				class_run_q[cmd.grant_cls] <= class_run_q[cmd.grant_cls] + RUN_W'(1);
			end
			if (cmd.finish) begin
				running_q                <= running_q - RUN_W'(1);
				class_run_q[cmd.fin_cls] <= class_run_q[cmd.fin_cls] - RUN_W'(1);
				done_q                   <= sat_inc(done_q);
				if (cmd.fin_failed)
					failed_q <= sat_inc(failed_q);
			end
		end
	end

	assign running   = running_q;
	assign class_run = class_run_q;
	assign submitted = submitted_q;
	assign done      = done_q;
	assign failed    = failed_q;

endmodule

`default_nettype wire
